// ===== sv/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/fba_pkg.sv =====
// Package for the fixed buffer bitmap allocator: sizes, payload structs,
// register indexes, controller states and command bundle. Depends on nothing.
package fba_pkg;

  localparam int MAX_BUFFERS  = 64;
  localparam int BUFFER_BYTES = 4096;
  localparam int PAGE_SHIFT   = 12;
  localparam int BUF_SHIFT    = $clog2(BUFFER_BYTES);
  localparam int CNT_W        = $clog2(MAX_BUFFERS + 1);
  localparam int IDX_W        = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int GRP_SIZE     = 8;
  localparam int GRP_BITS     = 3;
  localparam int NGRP         = (MAX_BUFFERS + GRP_SIZE - 1) / GRP_SIZE;
  localparam int GRP_W        = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int PAD_BITS     = NGRP * GRP_SIZE;
  localparam int VA_W         = 32;
  localparam int PA_W         = 37;
  localparam int VPAGE_W      = 20;
  localparam int PPAGE_W      = 25;
  localparam int COUNT_W      = 7;
  localparam int CFG_W        = 25;
  localparam int CFG_IDX_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIRT_BASE = 2'd0,
    REG_PHYS_BASE = 2'd1,
    REG_COUNT     = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef struct packed {
    logic            op;
    logic [VA_W-1:0] free_va;
  } in_t;

  typedef struct packed {
    logic            failed;
    logic [VA_W-1:0] buf_va;
    logic [PA_W-1:0] buf_pa;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PICK,
    ST_FREE
  } state_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic pick;
    logic free_apply;
  } ctrl_cmd_t;

endpackage

// ===== sv/fba_ctrl.sv =====
// Controller state machine of the allocator: sequences scan, pick and free.
// Depends on fba_pkg for the state type and the command struct.
module fba_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              op,
  output logic              busy,
  output fba_pkg::ctrl_cmd_t cmd
);

  fba_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fba_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      fba_pkg::ST_IDLE: begin
        if (start) begin
          state_next = (op == fba_pkg::OP_FREE) ? fba_pkg::ST_FREE : fba_pkg::ST_SCAN;
        end
      end
      fba_pkg::ST_SCAN: state_next = fba_pkg::ST_PICK;
      fba_pkg::ST_PICK: state_next = fba_pkg::ST_IDLE;
      fba_pkg::ST_FREE: state_next = fba_pkg::ST_IDLE;
      default:          state_next = fba_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      fba_pkg::ST_IDLE: begin
        busy        = 1'b0;
        cmd.capture = start;
      end
      fba_pkg::ST_SCAN: cmd.scan = 1'b1;
      fba_pkg::ST_PICK: cmd.pick = 1'b1;
      fba_pkg::ST_FREE: cmd.free_apply = 1'b1;
      default:          busy = 1'b1;
    endcase
  end

endmodule

// ===== sv/fba_dp.sv =====
// Datapath of the allocator: configuration registers, free map, two-level
// lowest-free search, address adders and the result register. Depends on fba_pkg.
module fba_dp (
  input  logic                        clk,
  input  logic                        rst,
  input  fba_pkg::ctrl_cmd_t          cmd,
  input  fba_pkg::in_t                item,
  input  logic                        cfg_we,
  input  logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fba_pkg::CFG_W-1:0]   cfg_data,
  output logic                        done,
  output fba_pkg::out_t               result
);

  logic [fba_pkg::VPAGE_W-1:0]     virt_base_page;
  logic [fba_pkg::PPAGE_W-1:0]     phys_base_page;
  logic [fba_pkg::COUNT_W-1:0]     buffer_count;
  logic [fba_pkg::MAX_BUFFERS-1:0] free_map;
  logic [fba_pkg::VA_W-1:0]        free_va;
  logic [fba_pkg::PAD_BITS-1:0]    cand;
  logic [fba_pkg::NGRP-1:0]        grp_any;

  logic [fba_pkg::CNT_W-1:0]       live_count;
  logic [fba_pkg::PAD_BITS-1:0]    cand_next;
  logic [fba_pkg::NGRP-1:0]        grp_any_next;
  logic [fba_pkg::GRP_W-1:0]       grp_sel;
  logic [fba_pkg::GRP_SIZE-1:0]    grp_bits;
  logic [fba_pkg::GRP_BITS-1:0]    bit_sel;
  logic                            hit;
  logic [fba_pkg::CNT_W-1:0]       slot;
  logic [fba_pkg::VA_W-1:0]        va_base;
  logic [fba_pkg::PA_W-1:0]        pa_base;
  logic [fba_pkg::VA_W-1:0]        diff;
  logic                            free_ok;

  always_comb begin
    live_count = (32'(buffer_count) > 32'(fba_pkg::MAX_BUFFERS))
               ? fba_pkg::CNT_W'(fba_pkg::MAX_BUFFERS) : fba_pkg::CNT_W'(buffer_count);
    cand_next = '0;
    for (int i = 0; i < fba_pkg::MAX_BUFFERS; i++) begin
      cand_next[i] = free_map[i] && (32'(i) < 32'(live_count));
    end
    for (int g = 0; g < fba_pkg::NGRP; g++) begin
      grp_any_next[g] = |cand_next[g*fba_pkg::GRP_SIZE +: fba_pkg::GRP_SIZE];
    end
  end

  always_comb begin
    grp_sel = '0;
    for (int g = fba_pkg::NGRP - 1; g >= 0; g--) begin
      if (grp_any[g]) begin
        grp_sel = fba_pkg::GRP_W'(g);
      end
    end
    grp_bits = cand[32'(grp_sel)*fba_pkg::GRP_SIZE +: fba_pkg::GRP_SIZE];
    bit_sel  = '0;
    for (int b = fba_pkg::GRP_SIZE - 1; b >= 0; b--) begin
      if (grp_bits[b]) begin
        bit_sel = fba_pkg::GRP_BITS'(b);
      end
    end
    hit  = |grp_any;
    slot = hit ? ((fba_pkg::CNT_W'(grp_sel) << fba_pkg::GRP_BITS) | fba_pkg::CNT_W'(bit_sel))
               : live_count;
    va_base = {virt_base_page, {fba_pkg::PAGE_SHIFT{1'b0}}};
    pa_base = {phys_base_page, {fba_pkg::PAGE_SHIFT{1'b0}}};
  end

  always_comb begin
    diff    = free_va - va_base;
    free_ok = (free_va >= va_base)
           && (free_va[fba_pkg::BUF_SHIFT-1:0] == '0)
           && ((diff >> fba_pkg::BUF_SHIFT) < 32'(live_count));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      virt_base_page <= '0;
      phys_base_page <= '0;
      buffer_count   <= '0;
      free_map       <= '1;
      done           <= 1'b0;
    end else begin
      done <= cmd.pick;
      if (cfg_we) begin
        unique case (cfg_index)
          fba_pkg::REG_VIRT_BASE: virt_base_page <= cfg_data[fba_pkg::VPAGE_W-1:0];
          fba_pkg::REG_PHYS_BASE: phys_base_page <= cfg_data[fba_pkg::PPAGE_W-1:0];
          fba_pkg::REG_COUNT: begin
            buffer_count <= cfg_data[fba_pkg::COUNT_W-1:0];
            free_map     <= '1;
          end
          default: ;
        endcase
      end
      if (cmd.pick && hit) begin
        free_map[slot[fba_pkg::IDX_W-1:0]] <= 1'b0;
      end
      if (cmd.free_apply && free_ok) begin
        free_map[diff[fba_pkg::BUF_SHIFT +: fba_pkg::IDX_W]] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      free_va <= item.free_va;
    end
    if (cmd.scan) begin
      cand    <= cand_next;
      grp_any <= grp_any_next;
    end
    if (cmd.pick) begin
      result.failed <= !hit;
      result.buf_va <= va_base + (fba_pkg::VA_W'(slot) << fba_pkg::BUF_SHIFT);
      result.buf_pa <= pa_base + (fba_pkg::PA_W'(slot) << fba_pkg::BUF_SHIFT);
    end
  end

endmodule

// ===== sv/fixed_buffer_bitmap_allocator.sv =====
// Top level of the fixed buffer bitmap allocator: joins controller and datapath.
// Depends on fba_pkg, fba_ctrl and fba_dp.
//
// Usage: an item is taken at a rising edge with start high and busy low.
// An allocate item (op 0) searches the free map for the lowest free buffer
// below the buffer count, marks it used and returns its virtual and physical
// addresses; failed is set when no buffer is free. A free item (op 1) marks
// the buffer at free_va free when the address is aligned, at or above the
// virtual base and below the count; it returns nothing.
// An allocate passes through the scan and pick states; done is registered
// from the pick state together with the result and is high for one cycle.
// Busy is high in the scan, pick and free states, so no new item is taken
// while an allocate or a free is still in its states.
// The two-level search is split over the states: scan masks the map and
// reduces it to group flags, pick picks group and bit and adds the offset.
// The receiver cannot stall: each result transfer happens in its done cycle.
// Configuration: cfg_we writes register cfg_index at once; write only while
// idle, which the block itself does not enforce; writing the count marks
// every buffer free. Reset clears the registers and marks every buffer free.
module fixed_buffer_bitmap_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  fba_pkg::in_t                  item,
  input  logic                          cfg_we,
  input  logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fba_pkg::CFG_W-1:0]     cfg_data,
  output logic                          done,
  output fba_pkg::out_t                 result
);

  fba_pkg::ctrl_cmd_t cmd;

  fba_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .op    (item.op),
    .busy  (busy),
    .cmd   (cmd)
  );

  fba_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

endmodule

// ===== sv/fba_checker.sv =====
// Port-level checker for the allocator, bound to the top level.
// Depends on fba_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fba_checker (
  input logic         clk,
  input logic         rst,
  input logic         start,
  input logic         busy,
  input fba_pkg::in_t item
  ,input logic        done
);

  logic alloc_acc;
  logic free_acc;

  assign alloc_acc = start && !busy && (item.op == fba_pkg::OP_ALLOC);
  assign free_acc  = start && !busy && (item.op == fba_pkg::OP_FREE);

  `ASSERT_IMPL(a_alloc_result, clk, rst, alloc_acc, ##1 !done ##1 !done ##1 done, "allocate without result in three cycles")
  `ASSERT_NEXT(a_free_silent, clk, rst, free_acc, !done ##1 !done, "free transfer produced a result")
  `ASSERT_NEXT(a_alloc_busy, clk, rst, alloc_acc, busy ##1 busy ##1 !busy, "allocate busy window is wrong")
  `ASSERT_IMPL(a_done_after_busy, clk, rst, done, !busy && $past(busy), "result transfer outside an allocate")

endmodule

bind fixed_buffer_bitmap_allocator fba_checker u_fba_checker (.*);

// ===== tb/sv/fba_grant_checker.sv =====
// Checker for the fixed buffer bitmap allocator: it keeps its own free map
// and registers, predicts each allocate grant and compares it with the result.
// Depends on fba_pkg.
`timescale 1ns / 100ps

module fba_grant_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  fba_pkg::in_t                  item,
  input  logic                          cfg_we,
  input  logic [fba_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fba_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          done,
  input  fba_pkg::out_t                 result,
  output int                            failures,
  output int                            pending
);
  import fba_pkg::*;

  logic [VPAGE_W-1:0]     virt_page;
  logic [PPAGE_W-1:0]     phys_page;
  logic [COUNT_W-1:0]     count_reg;
  logic [MAX_BUFFERS-1:0] free_bits;
  out_t                   expected_grants[$];
  int                     fail_count = 0;

  assign failures = fail_count;

  function automatic int live_buffers();
    return (count_reg > MAX_BUFFERS) ? MAX_BUFFERS : int'(count_reg);
  endfunction

  function automatic out_t grant_lowest();
    int          live;
    int          slot;
    logic [63:0] offset;
    logic [63:0] va_sum;
    logic [63:0] pa_sum;
    out_t        grant;
    live = live_buffers();
    slot = live;
    for (int i = live - 1; i >= 0; i--) begin
      if (free_bits[i]) begin
        slot = i;
      end
    end
    offset = 64'(slot) * BUFFER_BYTES;
    va_sum = (64'(virt_page) << PAGE_SHIFT) + offset;
    pa_sum = (64'(phys_page) << PAGE_SHIFT) + offset;
    grant.failed = (slot >= live);
    grant.buf_va = va_sum[VA_W-1:0];
    grant.buf_pa = pa_sum[PA_W-1:0];
    if (!grant.failed) begin
      free_bits[slot] = 1'b0;
    end
    return grant;
  endfunction

  function automatic void release_buffer(input logic [VA_W-1:0] va);
    logic [VA_W-1:0] va_base;
    logic [VA_W-1:0] idx;
    va_base = {virt_page, {PAGE_SHIFT{1'b0}}};
    if (va >= va_base && va[BUF_SHIFT-1:0] == '0) begin
      idx = (va - va_base) >> BUF_SHIFT;
      if (idx < live_buffers()) begin
        free_bits[idx] = 1'b1;
      end
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      virt_page = '0;
      phys_page = '0;
      count_reg = '0;
      free_bits = '1;
      expected_grants.delete();
    end else begin
      if (done) begin
        if (expected_grants.size() == 0) begin
          $error("result transfer with no allocate outstanding");
          fail_count++;
        end else begin
          want = expected_grants.pop_front();
          if (result.failed !== want.failed) begin
            $error("failed: expected %0d, got %0d", want.failed, result.failed);
            fail_count++;
          end
          if (result.buf_va !== want.buf_va) begin
            $error("buf_va: expected %h, got %h", want.buf_va, result.buf_va);
            fail_count++;
          end
          if (result.buf_pa !== want.buf_pa) begin
            $error("buf_pa: expected %h, got %h", want.buf_pa, result.buf_pa);
            fail_count++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_VIRT_BASE: virt_page = cfg_data[VPAGE_W-1:0];
          REG_PHYS_BASE: phys_page = cfg_data[PPAGE_W-1:0];
          REG_COUNT: begin
            count_reg = cfg_data[COUNT_W-1:0];
            free_bits = '1;
          end
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (item.op == OP_ALLOC) begin
          expected_grants.push_back(grant_lowest());
        end else begin
          release_buffer(item.free_va);
        end
      end
    end
    pending <= expected_grants.size();
  end

endmodule

// ===== tb/sv/tb_fixed_buffer_bitmap_allocator.sv =====
// Top of the fixed buffer bitmap allocator testbench: clock, reset, register
// writes and allocate/free stimulus. Depends on fba_pkg, the allocator and
// fba_grant_checker, which predicts and compares every result transfer.
`timescale 1ns / 100ps

module tb_fixed_buffer_bitmap_allocator;
  import fba_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 start;
  logic                 busy;
  in_t                  item;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 done;
  out_t                 result;
  int                   failures;
  int                   pending;

  logic [VA_W-1:0]      region_va;
  int                   live_now;

  fixed_buffer_bitmap_allocator uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result)
  );

  fba_grant_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .item      (item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .done      (done),
    .result    (result),
    .failures  (failures),
    .pending   (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("[fixed_buffer_bitmap_allocator] ERROR");
    $finish;
  end

  task automatic issue(input op_t op, input logic [VA_W-1:0] va);
    start <= 1'b1;
    item.op <= op;
    item.free_va <= va;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic gap(input int cycles);
    start <= 1'b0;
    item.op <= 1'($urandom_range(1));
    item.free_va <= $urandom();
    repeat (cycles) @(posedge clk);
  endtask

  // Waits until every allocate has returned and the block has gone idle.
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_VIRT_BASE: region_va = {data[VPAGE_W-1:0], {PAGE_SHIFT{1'b0}}};
      REG_COUNT: begin
        live_now = (data[COUNT_W-1:0] > MAX_BUFFERS) ? MAX_BUFFERS
                                                     : int'(data[COUNT_W-1:0]);
      end
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_region(input logic [VPAGE_W-1:0] vp, input logic [PPAGE_W-1:0] pp,
                            input logic [COUNT_W-1:0] cnt, input bit write_count);
    logic [CFG_W-1:0] word;
    settle();
    word = CFG_W'($urandom());
    word[VPAGE_W-1:0] = vp;
    write_reg(REG_VIRT_BASE, word);
    write_reg(REG_PHYS_BASE, pp);
    if (write_count) begin
      word = CFG_W'($urandom());
      word[COUNT_W-1:0] = cnt;
      write_reg(REG_COUNT, word);
    end
    cfg_we <= 1'b0;
  endtask

  // Most frees name an aligned address from the base up to one past the last
  // buffer; the rest are misaligned, below the base or arbitrary.
  function automatic in_t random_item(input int alloc_pct);
    in_t it;
    int  idx;
    it.free_va = $urandom();
    if ($urandom_range(99) < alloc_pct) begin
      it.op = OP_ALLOC;
    end else begin
      it.op = OP_FREE;
      case ($urandom_range(9))
        0: ;
        1: begin
          it.free_va = region_va + (32'($urandom_range(live_now)) << BUF_SHIFT)
                       + 32'($urandom_range(1, BUFFER_BYTES - 1));
        end
        2: begin
          it.free_va = region_va - (32'($urandom_range(1, 4)) << BUF_SHIFT);
        end
        default: begin
          idx = $urandom_range(live_now);
          it.free_va = region_va + (32'(idx) << BUF_SHIFT);
        end
      endcase
    end
    return it;
  endfunction

  initial begin
    int                 processed;
    int                 phase;
    int                 n;
    int                 alloc_pct;
    bit                 quiet;
    in_t                it;
    logic [COUNT_W-1:0] cnt;
    logic [VPAGE_W-1:0] vp;
    logic [PPAGE_W-1:0] pp;

    rst <= 1'b1;
    start <= 1'b0;
    item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_VIRT_BASE;
    cfg_data <= '0;
    region_va = '0;
    live_now = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // With the reset count of zero every allocate fails and frees do nothing.
    issue(OP_ALLOC, 32'hFFFF_FFFF);
    issue(OP_FREE, 32'h0000_0000);

    // Top of both address spaces: addresses wrap past the end.
    set_region(20'hFFFFF, 25'h1FFFFFF, 7'd3, 1'b1);
    repeat (4) issue(OP_ALLOC, 32'h0000_0000);
    issue(OP_FREE, 32'hFFFF_F000);
    issue(OP_FREE, 32'hFFFF_F001);
    issue(OP_FREE, 32'h0000_0000);
    issue(OP_ALLOC, 32'h0000_0000);
    issue(OP_ALLOC, 32'h0000_0000);

    set_region(20'h00010, 25'h0000000, 7'd2, 1'b1);
    issue(OP_FREE, 32'h0000_F000);
    issue(OP_FREE, 32'h0001_2000);
    issue(OP_FREE, 32'h0001_0000);
    issue(OP_ALLOC, 32'hFFFF_FFFF);
    issue(OP_ALLOC, 32'h0000_0000);
    issue(OP_ALLOC, 32'h0000_0000);
    issue(OP_FREE, 32'h0001_1000);

    // Moving the base alone keeps the free map.
    set_region(20'h00020, 25'h0000000, 7'd0, 1'b0);
    issue(OP_ALLOC, 32'h0000_0000);

    // A count above capacity acts as the capacity.
    set_region(20'h00000, 25'h1000000, 7'd127, 1'b1);
    issue(OP_ALLOC, 32'h0000_0000);
    issue(OP_FREE, 32'h0003_F000);
    issue(OP_FREE, 32'h0004_0000);
    issue(OP_ALLOC, 32'h0000_0000);

    processed = 0;
    phase = 0;
    while (processed < 2000) begin
      case ($urandom_range(7))
        0: cnt = 7'd0;
        1: cnt = 7'd1;
        2: cnt = 7'd64;
        3: cnt = 7'($urandom_range(65, 127));
        4: cnt = 7'd63;
        default: cnt = 7'($urandom_range(2, 12));
      endcase
      case ($urandom_range(3))
        0: vp = '0;
        1: vp = '1;
        default: vp = VPAGE_W'($urandom());
      endcase
      case ($urandom_range(3))
        0: pp = '0;
        1: pp = '1;
        default: pp = PPAGE_W'($urandom());
      endcase
      set_region(vp, pp, cnt, phase == 0 || $urandom_range(3) != 0);
      alloc_pct = $urandom_range(20, 90);
      quiet = (phase == 3);
      n = quiet ? 300 : $urandom_range(40, 120);
      for (int k = 0; k < n; k++) begin
        if (!quiet && $urandom_range(99) < 10) begin
          gap($urandom_range(1, 4));
        end
        if (!quiet && $urandom_range(199) == 0) begin
          settle();
        end
        it = random_item(alloc_pct);
        issue(op_t'(it.op), it.free_va);
        processed++;
      end
      phase++;
    end

    start <= 1'b0;
    for (int w = 0; w < 1000 && (pending != 0 || busy); w++) @(posedge clk);
    repeat (8) @(posedge clk);
    if (failures == 0 && pending == 0) begin
      $display("[fixed_buffer_bitmap_allocator] OK");
    end else begin
      $display("[fixed_buffer_bitmap_allocator] ERROR");
    end
    $finish;
  end

endmodule
